// ===== sv/piwu_pkg.sv =====
// ----------------------------------------------------------------------------
// piwu_pkg: shared constants and types of the packed index word unpacker
// field widths, register codes and the decoded geometry handed between blocks
// ----------------------------------------------------------------------------
package piwu_pkg;

	// default values of the top level parameters
	localparam int WORD_BITS_DEF      = 64;
	localparam int MIN_INDEX_BITS_DEF = 4;
	localparam int MAX_INDEX_BITS_DEF = 12;

	// fixed port widths
	localparam int INPUT_BITS     = 64;
	localparam int PSIZE_BITS     = 13;
	localparam int SECTION_Y_BITS = 4;
	localparam int INDEX_BITS     = 12;
	localparam int POSITION_BITS  = 16;
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 13;

	// internal widths: a field is at most 16 bits wide, at most 16 fields per word
	localparam int FIELD_BITS   = 16;
	localparam int WIDTH_BITS   = 5;
	localparam int COUNT_BITS   = 5;
	localparam int RESULT_LIMIT = 16;

	localparam int PSIZE_RESET = 16;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_PALETTE_SIZE = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SECTION_Y    = 4'd1;

	// geometry decoded from the configuration registers
	typedef struct packed {
		logic [WIDTH_BITS-1:0]     width;
		logic [COUNT_BITS-1:0]     count;
		logic [SECTION_Y_BITS-1:0] section_y;
	} geom_t;

endpackage

// ===== sv/piwu_cfg.sv =====
// ----------------------------------------------------------------------------
// piwu_cfg: configuration registers and index geometry decode
// holds palette size and section number, derives field width and field count
// ----------------------------------------------------------------------------
module piwu_cfg #(
	parameter int WORD_BITS      = piwu_pkg::WORD_BITS_DEF,
	parameter int MIN_INDEX_BITS = piwu_pkg::MIN_INDEX_BITS_DEF,
	parameter int MAX_INDEX_BITS = piwu_pkg::MAX_INDEX_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [piwu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [piwu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output piwu_pkg::geom_t                     geom
);
	import piwu_pkg::*;

	logic [PSIZE_BITS-1:0]     palette_size_q;
	logic [SECTION_Y_BITS-1:0] section_y_q;
	logic [PSIZE_BITS-1:0]     size_m1;
	logic [WIDTH_BITS-1:0]     log_bits;
	logic [WIDTH_BITS-1:0]     width;
	logic [COUNT_BITS-1:0]     count_tab [2**WIDTH_BITS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= PSIZE_BITS'(PSIZE_RESET);
			section_y_q    <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_PALETTE_SIZE) begin
				palette_size_q <= cfg_data[PSIZE_BITS-1:0];
			end else if (cfg_index == REG_SECTION_Y) begin
				section_y_q <= cfg_data[SECTION_Y_BITS-1:0];
			end
		end
	end

	// ceil(log2(n)) is the bit length of n-1; sizes zero and one give zero
	assign size_m1 = palette_size_q - PSIZE_BITS'(1);

	always_comb begin
		log_bits = '0;
		if (palette_size_q > PSIZE_BITS'(1)) begin
			for (int b = 0; b < PSIZE_BITS; b++) begin
				if (size_m1[b]) log_bits = WIDTH_BITS'(b + 1);
			end
		end
		width = log_bits;
		if (width < WIDTH_BITS'(MIN_INDEX_BITS)) width = WIDTH_BITS'(MIN_INDEX_BITS);
		if (width > WIDTH_BITS'(MAX_INDEX_BITS)) width = WIDTH_BITS'(MAX_INDEX_BITS);
	end

	// fields per word for each width, capped at the result limit
	for (genvar g = 0; g < 2**WIDTH_BITS; g++) begin : g_count
		localparam int DIV = (g == 0) ? 1 : g;
		localparam int RAW = WORD_BITS / DIV;
		localparam int CNT = (RAW > RESULT_LIMIT) ? RESULT_LIMIT : RAW;
		assign count_tab[g] = COUNT_BITS'(CNT);
	end

	assign geom.width     = width;
	assign geom.count     = count_tab[width];
	assign geom.section_y = section_y_q;

endmodule

// ===== sv/piwu_unpack.sv =====
// ----------------------------------------------------------------------------
// piwu_unpack: word register, field extraction and result register
// holds a word, peels a field per cycle unless stalled, tags it with position
// ----------------------------------------------------------------------------
module piwu_unpack #(
	parameter int WORD_BITS = piwu_pkg::WORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [piwu_pkg::INPUT_BITS-1:0]    packed_word,
	input  logic                               section_start,
	input  piwu_pkg::geom_t                    geom,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [piwu_pkg::INDEX_BITS-1:0]    pal_index,
	output logic [piwu_pkg::POSITION_BITS-1:0] position,
	output logic                               last
);
	import piwu_pkg::*;

	// word stage
	logic                     valid_s1;
	logic [WORD_BITS-1:0]     word_s1;
	logic [WIDTH_BITS-1:0]    width_s1;
	logic [COUNT_BITS-1:0]    remain_s1;
	logic                     start_s1;

	// result register and running position
	logic                     out_valid_q;
	logic [INDEX_BITS-1:0]    pal_index_q;
	logic [POSITION_BITS-1:0] position_q;
	logic                     last_q;
	logic [POSITION_BITS-1:0] pos_count_q;

	logic                     fire;
	logic                     final_field;
	logic                     accept;
	logic [FIELD_BITS:0]      mask_wide;
	logic [FIELD_BITS-1:0]    field;
	logic [POSITION_BITS-1:0] pos_cur;

	assign fire        = valid_s1 && (!out_valid_q || out_ready);
	assign final_field = (remain_s1 == COUNT_BITS'(1));
	assign in_ready    = !valid_s1 || (fire && final_field);
	assign accept      = in_valid && in_ready;

	assign mask_wide = ((FIELD_BITS + 1)'(1) << width_s1) - (FIELD_BITS + 1)'(1);
	assign field     = word_s1[FIELD_BITS-1:0] & mask_wide[FIELD_BITS-1:0];

	// section start reloads the high byte with section_y * 16
	assign pos_cur = start_s1 ? {geom.section_y, 4'b0000, pos_count_q[7:0]} : pos_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pos_count_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire && final_field) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
				pos_count_q <= pos_cur + POSITION_BITS'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1   <= packed_word[WORD_BITS-1:0];
			width_s1  <= geom.width;
			remain_s1 <= geom.count;
			start_s1  <= section_start;
		end else if (fire) begin
			word_s1   <= word_s1 >> width_s1;
			remain_s1 <= remain_s1 - COUNT_BITS'(1);
			start_s1  <= 1'b0;
		end
		if (fire) begin
			pal_index_q <= field[INDEX_BITS-1:0];
			position_q  <= pos_cur;
			last_q      <= final_field;
		end
	end

	assign out_valid = out_valid_q;
	assign pal_index = pal_index_q;
	assign position  = position_q;
	assign last      = last_q;

endmodule

// ===== sv/packed_index_word_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// packed_index_word_unpacker_unit: top level of the packed index word unpacker
// splits 64-bit packed words into palette indices tagged with a position
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready carries packed_word and section_start;
//     one word yields min(16, WORD_BITS / width) indices, width being
//     max(MIN_INDEX_BITS, ceil(log2(palette_size))) capped at MAX_INDEX_BITS
//   output channel: out_valid/out_ready carries pal_index, position and
//     last, which marks the final index of a word
//   config channel: cfg_valid/cfg_ready with cfg_index (0 palette size,
//     1 section y) and cfg_data; always ready, write only while idle
//   path: a word enters the word register, its indices the result register
//   throughput: one index per cycle while the receiver keeps up, set by
//     the single result register; a word holds 5 to 16 indices at 64 bits
//     and the next word is taken at the edge its last index moves into the
//     result register
//   stall: a stalled receiver freezes the result register and the word
//     register; the next word is taken only when the held word drains
//   reset: position counter cleared, both stages empty, palette size 16,
//     section y 0
// ----------------------------------------------------------------------------
module packed_index_word_unpacker_unit #(
	parameter int WORD_BITS      = piwu_pkg::WORD_BITS_DEF,
	parameter int MIN_INDEX_BITS = piwu_pkg::MIN_INDEX_BITS_DEF,
	parameter int MAX_INDEX_BITS = piwu_pkg::MAX_INDEX_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [piwu_pkg::INPUT_BITS-1:0]     packed_word,
	input  logic                                section_start,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [piwu_pkg::INDEX_BITS-1:0]     pal_index,
	output logic [piwu_pkg::POSITION_BITS-1:0]  position,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [piwu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [piwu_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import piwu_pkg::*;

	// width, count and section number decoded from the registers
	geom_t geom;

	// configuration registers and geometry decode
	piwu_cfg #(
		.WORD_BITS      (WORD_BITS),
		.MIN_INDEX_BITS (MIN_INDEX_BITS),
		.MAX_INDEX_BITS (MAX_INDEX_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	// word register, field peel and result register
	piwu_unpack #(
		.WORD_BITS (WORD_BITS)
	) u_unpack (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.packed_word   (packed_word),
		.section_start (section_start),
		.geom          (geom),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pal_index     (pal_index),
		.position      (position),
		.last          (last)
	);

endmodule

// ===== sv/piwu_checker.sv =====
// ----------------------------------------------------------------------------
// piwu_checker: port level checks of the packed index word unpacker
// watches output ordering, position stepping and input back pressure
// ----------------------------------------------------------------------------
module piwu_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [piwu_pkg::INDEX_BITS-1:0]    pal_index,
	input logic [piwu_pkg::POSITION_BITS-1:0] position,
	input logic                               last
);
	import piwu_pkg::*;

	// a stalled index stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled index keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pal_index) && $stable(position) && $stable(last))
		else $error("output payload changed while stalled");

	// indices of one word come back to back
	a_word_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a word");

	// position steps by one inside a word
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> position == $past(position) + POSITION_BITS'(1))
		else $error("position did not step by one");

	// no new word while the held word is blocked mid way
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && !last |-> !in_ready)
		else $error("input ready while a word is still pending");

endmodule

bind packed_index_word_unpacker_unit piwu_checker u_piwu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pal_index (pal_index),
	.position  (position),
	.last      (last)
);

// ===== dv/tb_packed_index_word_unpacker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_packed_index_word_unpacker_unit: self-checking bench of the word unpacker
// drives packed words through the input channel and checks every unpacked
// index, its position tag and the end-of-word flag against an in-bench model
// of the unpacker; a table of directed words comes first, random phases follow
// ----------------------------------------------------------------------------
module tb_packed_index_word_unpacker_unit;

	import piwu_pkg::*;

	// run control
	localparam int RESET_CYCLES = 8;
	localparam int IDLE_PCT     = 22;
	localparam int MAX_GAP      = 6;
	localparam int HOLD_CYCLES  = 120;
	localparam int SETTLE       = 4;
	localparam int TAIL_CYCLES  = 8;
	localparam int PHASE_WORDS  = 20;
	localparam int RAND_PHASES  = 6;
	localparam int MAX_REPORTS  = 40;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// register index with nothing behind it, writes there must change nothing
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 4'd9;

	// one unpacked index as it leaves the block
	typedef struct packed {
		logic [INDEX_BITS-1:0]    index;
		logic [POSITION_BITS-1:0] pos;
		logic                     last;
	} index_result_t;

	// one directed word, with the first index and position typed in where known
	typedef struct packed {
		logic [PSIZE_BITS-1:0]     psize;
		logic [SECTION_Y_BITS-1:0] section;
		logic [INPUT_BITS-1:0]     word;
		logic                      start;
		logic                      has_idx;
		logic [INDEX_BITS-1:0]     want_idx;
		logic                      has_pos;
		logic [POSITION_BITS-1:0]  want_pos;
	} stim_row_t;

	localparam int DIR_ROWS = 22;
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		// reset settings: width 4, position counts up from zero
		'{13'd16,   4'd0,  64'h0000_0000_0000_0000, 1'b0, 1'b1, 12'h000, 1'b1, 16'h0000},
		'{13'd16,   4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 12'h00F, 1'b1, 16'h0010},
		'{13'd16,   4'd0,  64'h0123_4567_89AB_CDEF, 1'b1, 1'b1, 12'h00F, 1'b1, 16'h0020},
		// section start with the top section: high byte becomes f0
		'{13'd16,   4'd15, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, 12'h00E, 1'b1, 16'hF030},
		'{13'd16,   4'd15, 64'h8000_0000_0000_0001, 1'b0, 1'b1, 12'h001, 1'b1, 16'hF040},
		// palette of zero and of one entry fall back to the minimum width
		'{13'd0,    4'd15, 64'hA5A5_5A5A_F00F_0FF0, 1'b0, 1'b0, 12'h000, 1'b0, 16'h0000},
		'{13'd1,    4'd15, 64'h0F1E_2D3C_4B5A_6978, 1'b1, 1'b0, 12'h000, 1'b0, 16'h0000},
		// every width step, just above and at some powers of two
		'{13'd17,   4'd15, 64'hDEAD_BEEF_CAFE_F00D, 1'b0, 1'b0, 12'h000, 1'b0, 16'h0000},
		'{13'd32,   4'd7,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 12'h01F, 1'b0, 16'h0000},
		'{13'd33,   4'd7,  64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0, 12'h000, 1'b0, 16'h0000},
		'{13'd64,   4'd7,  64'h0000_0000_0000_0000, 1'b0, 1'b1, 12'h000, 1'b0, 16'h0000},
		'{13'd65,   4'd7,  64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 12'h07F, 1'b0, 16'h0000},
		'{13'd129,  4'd7,  64'h0102_0408_1020_4080, 1'b0, 1'b1, 12'h080, 1'b0, 16'h0000},
		'{13'd256,  4'd7,  64'hC3C3_3C3C_9669_6996, 1'b1, 1'b0, 12'h000, 1'b0, 16'h0000},
		'{13'd257,  4'd7,  64'h5555_AAAA_5555_AAAA, 1'b0, 1'b0, 12'h000, 1'b0, 16'h0000},
		'{13'd513,  4'd7,  64'hAAAA_5555_AAAA_5555, 1'b0, 1'b0, 12'h000, 1'b0, 16'h0000},
		'{13'd1025, 4'd7,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 12'h7FF, 1'b0, 16'h0000},
		'{13'd2048, 4'd3,  64'h0F0F_F0F0_0F0F_F0F0, 1'b1, 1'b0, 12'h000, 1'b0, 16'h0000},
		'{13'd2049, 4'd3,  64'h8421_8421_8421_8421, 1'b0, 1'b0, 12'h000, 1'b0, 16'h0000},
		// widest fields and palettes past the width limit
		'{13'd4096, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 12'hFFF, 1'b0, 16'h0000},
		'{13'd4097, 4'd0,  64'h0000_0000_0000_0FFF, 1'b0, 1'b1, 12'hFFF, 1'b0, 16'h0000},
		'{13'd8191, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 12'hFFF, 1'b0, 16'h0000}
	};

	// dut signals, all inputs known from time zero
	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      in_valid      = 1'b0;
	logic                      in_ready;
	logic [INPUT_BITS-1:0]     packed_word   = '0;
	logic                      section_start = 1'b0;
	logic                      out_valid;
	logic                      out_ready     = 1'b0;
	logic [INDEX_BITS-1:0]     pal_index;
	logic [POSITION_BITS-1:0]  position;
	logic                      last;
	logic                      cfg_valid     = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;

	// model state: register copies and the position counter
	logic [PSIZE_BITS-1:0]     cur_psize     = PSIZE_RESET[PSIZE_BITS-1:0];
	logic [SECTION_Y_BITS-1:0] cur_section   = '0;
	logic [POSITION_BITS-1:0]  next_position = '0;

	index_result_t pending_indices [$];

	// traffic shaping
	logic steady  = 1'b0;	// no random idling on either side
	logic rx_hold = 1'b0;	// long receiver stall
	bit   hold_go = 1'b0;

	int          error_count = 0;
	int unsigned cycle_count = 0;
	bit          spare_poked = 1'b0;

	packed_index_word_unpacker_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.packed_word   (packed_word),
		.section_start (section_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pal_index     (pal_index),
		.position      (position),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("cycle %0d: %s", cycle_count, msg);
	endtask

	// index width: ceil(log2(palette size)), clamped to the min and max width
	function automatic int field_width(input logic [PSIZE_BITS-1:0] psize);
		int w;
		w = 0;
		while (w < FIELD_BITS && (32'd1 << w) < psize)
			w++;
		if (w < MIN_INDEX_BITS_DEF)
			w = MIN_INDEX_BITS_DEF;
		if (w > MAX_INDEX_BITS_DEF)
			w = MAX_INDEX_BITS_DEF;
		return w;
	endfunction

	// split one accepted word into its indices and queue them with positions
	task automatic predict_indices(input logic [INPUT_BITS-1:0] word, input logic start,
			input logic has_idx, input logic [INDEX_BITS-1:0] want_idx,
			input logic has_pos, input logic [POSITION_BITS-1:0] want_pos);
		int w;
		int n;
		logic [INPUT_BITS-1:0] mask;
		index_result_t r;
		w = field_width(cur_psize);
		n = WORD_BITS_DEF / w;
		if (n > RESULT_LIMIT)
			n = RESULT_LIMIT;
		mask = (64'd1 << w) - 64'd1;
		// section start: high byte becomes section * 16, low byte stays
		if (start)
			next_position[15:8] = {cur_section, 4'd0};
		for (int j = 0; j < n; j++) begin
			r.index = INDEX_BITS'((word >> (j * w)) & mask);
			r.pos   = next_position;
			r.last  = (j == n - 1);
			// typed-in first index and position override the computed ones
			if (j == 0 && has_idx)
				r.index = want_idx;
			if (j == 0 && has_pos)
				r.pos = want_pos;
			pending_indices.push_back(r);
			next_position++;
		end
	endtask

	// offer one word, idling first at random; returns in the cycle it is taken
	task automatic send_word(input logic [INPUT_BITS-1:0] word, input logic start,
			input logic has_idx = 1'b0, input logic [INDEX_BITS-1:0] want_idx = '0,
			input logic has_pos = 1'b0, input logic [POSITION_BITS-1:0] want_pos = '0);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		packed_word   <= word;
		section_start <= start;
		do @(posedge clk); while (!in_ready);
		predict_indices(word, start, has_idx, want_idx, has_pos, want_pos);
	endtask

	// stop sending and wait until every queued index is out, block idle again
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_indices.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// write both registers back to back, optionally the spare index as well
	task automatic program_regs(input logic [PSIZE_BITS-1:0] psize,
			input logic [SECTION_Y_BITS-1:0] section, input bit poke_spare);
		logic [CFG_INDEX_BITS-1:0] idx_list [3];
		logic [CFG_DATA_BITS-1:0]  data_list [3];
		int writes;
		idx_list[0]  = REG_PALETTE_SIZE;
		data_list[0] = psize;
		idx_list[1]  = REG_SECTION_Y;
		// upper data bits are junk, only the low nibble counts
		data_list[1] = CFG_DATA_BITS'($urandom);
		data_list[1][SECTION_Y_BITS-1:0] = section;
		idx_list[2]  = REG_SPARE;
		data_list[2] = CFG_DATA_BITS'($urandom);
		writes = poke_spare ? 3 : 2;
		for (int k = 0; k < writes; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx_list[k];
			cfg_data  <= data_list[k];
			do @(posedge clk); while (!cfg_ready);
			case (idx_list[k])
				REG_PALETTE_SIZE: cur_psize = data_list[k];
				REG_SECTION_Y:    cur_section = data_list[k][SECTION_Y_BITS-1:0];
				default:          ;	// no register there
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [INPUT_BITS-1:0] random_word();
		case ($urandom_range(0, 3))
			0:       return {$urandom, $urandom};
			1:       return ~(64'd1 << $urandom_range(0, 63));
			2:       return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom} & {$urandom, $urandom};
		endcase
	endfunction

	// palette sizes: extremes, small sizes, anything, and near powers of two
	function automatic logic [PSIZE_BITS-1:0] pick_palette_size();
		case ($urandom_range(0, 3))
			0: begin
				case ($urandom_range(0, 5))
					0:       return 13'd0;
					1:       return 13'd1;
					2:       return 13'd16;
					3:       return 13'd17;
					4:       return 13'd4096;
					default: return 13'd8191;
				endcase
			end
			1:       return PSIZE_BITS'($urandom_range(0, 64));
			2:       return PSIZE_BITS'($urandom_range(0, 8191));
			default: return PSIZE_BITS'((1 << $urandom_range(0, 12)) + $urandom_range(0, 1));
		endcase
	endfunction

	task automatic check_index();
		index_result_t want;
		if (pending_indices.size() == 0) begin
			report_mismatch($sformatf("index %03h at position %04h with no word pending",
				pal_index, position));
			return;
		end
		want = pending_indices.pop_front();
		if (pal_index !== want.index)
			report_mismatch($sformatf("pal_index %03h, expected %03h (position %04h)",
				pal_index, want.index, want.pos));
		if (position !== want.pos)
			report_mismatch($sformatf("position %04h, expected %04h", position, want.pos));
		if (last !== want.last)
			report_mismatch($sformatf("last %b, expected %b (position %04h)",
				last, want.last, want.pos));
	endtask

	// receiver: check on the handshake, then pick the next ready value
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_index();
			out_ready <= !rx_hold && (steady || $urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// long receiver stall, counted here while the sender keeps offering words
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, registers change only between drained words
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIR_TABLE[r].psize != cur_psize || DIR_TABLE[r].section != cur_section) begin
				drain_results();
				program_regs(DIR_TABLE[r].psize, DIR_TABLE[r].section, !spare_poked);
				spare_poked = 1'b1;
			end
			send_word(DIR_TABLE[r].word, DIR_TABLE[r].start, DIR_TABLE[r].has_idx,
				DIR_TABLE[r].want_idx, DIR_TABLE[r].has_pos, DIR_TABLE[r].want_pos);
		end

		// random phases: one with no idling, one under a long receiver stall
		for (int p = 0; p < RAND_PHASES; p++) begin
			drain_results();
			program_regs(pick_palette_size(), SECTION_Y_BITS'($urandom_range(0, 15)), 1'b0);
			steady <= (p == 0);
			if (p == 1)
				hold_go = 1'b1;
			for (int k = 0; k < PHASE_WORDS; k++)
				send_word(random_word(), 1'($urandom_range(0, 5) == 0));
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_indices.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/piwu_pkg.sv
sv/piwu_cfg.sv
sv/piwu_unpack.sv
sv/packed_index_word_unpacker_unit.sv
sv/piwu_checker.sv
dv/tb_packed_index_word_unpacker_unit.sv
